@@ hw/rtl/lnds_pkg.sv @@
// Shared widths and controller state type for the longest non-decreasing subsequence block.
package lnds_pkg;

    localparam int VALUE_W = 32;
    localparam int RUN_W   = 11;
    localparam int COUNT_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE
    } t_state;

endpackage

@@ hw/rtl/lnds_if.sv @@
// Valid/ready channel interfaces for the input values and the per-item results.
interface lnds_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [lnds_pkg::VALUE_W-1:0] value;
    logic                                start_req;

    modport source (output valid, output value, output start_req, input ready);
    modport sink   (input valid, input value, input start_req, output ready);
endinterface

interface lnds_out_if;
    logic                         valid;
    logic                         ready;
    logic [lnds_pkg::RUN_W-1:0]   run_length;
    logic [lnds_pkg::COUNT_W-1:0] removed_count;
    logic                         overflow;

    modport source (output valid, output run_length, output removed_count, output overflow,
                    input ready);
    modport sink   (input valid, input run_length, input removed_count, input overflow,
                    output ready);
endinterface

@@ hw/rtl/longest_nondecreasing_subsequence.sv @@
// Longest non-decreasing subsequence tracker: tail memory with a binary search sequencer.
//
//   channel   dir  handshake      payload
//   i_in      in   valid/ready    value (s32), start_req
//   o_out     out  valid/ready    run_length (11), removed_count (16), overflow
//
// Each request is accepted, then searched by binary search steps over the tail memory
// (at most ceil(log2(length+1)) steps, so 11 at a length of 1024), then written back.
// The tail memory read is registered, so each search step compares data read before it.
// Reset clears the length, item count and overflow flag; the tail memory is not cleared.
// A waiting result holds only the write-back; a new request is taken while it waits.
module longest_nondecreasing_subsequence #(
    parameter int MAX_LEN = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lnds_in_if.sink       i_in,
    lnds_out_if.source    o_out
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int VW = lnds_pkg::VALUE_W;
    localparam int RW = lnds_pkg::RUN_W;
    localparam int CW = lnds_pkg::COUNT_W;

    logic [VW-1:0] mem [MAX_LEN];

    lnds_pkg::t_state r_state, n_state;

    logic [LW-1:0] r_lo, n_lo;
    logic [LW-1:0] r_hi, n_hi;
    logic [LW-1:0] r_mid, n_mid;
    logic [LW-1:0] r_len, n_len;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [VW-1:0] r_value, n_value;
    logic [VW-1:0] r_rd_data;

    logic          r_out_valid, n_out_valid;
    logic [RW-1:0] r_out_run, n_out_run;
    logic [CW-1:0] r_out_rem, n_out_rem;
    logic          r_out_ovf, n_out_ovf;

    logic          in_ready;
    logic          accept;
    logic          slot_free;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          tail_gt;
    logic [LW-1:0] wb_len;
    logic [LW+RW-1:0] run_ext;
    logic [LW+CW-1:0] rem_ext;

    assign slot_free = !r_out_valid || o_out.ready;
    assign accept    = i_in.valid && in_ready;
    assign tail_gt   = $signed(r_rd_data) > $signed(r_value);

    always_comb begin
        n_state = r_state;
        case (r_state)
            lnds_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in.start_req || (r_len == '0)) begin
                        n_state = lnds_pkg::ST_WRITE;
                    end else begin
                        n_state = lnds_pkg::ST_SEARCH;
                    end
                end
            end
            lnds_pkg::ST_SEARCH: begin
                if (n_lo >= n_hi) begin
                    n_state = lnds_pkg::ST_WRITE;
                end
            end
            lnds_pkg::ST_WRITE: begin
                if (slot_free) begin
                    n_state = lnds_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lnds_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_lo[AW-1:0];
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_value     = r_value;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_run   = r_out_run;
        n_out_rem   = r_out_rem;
        n_out_ovf   = r_out_ovf;
        wb_len      = r_len;
        run_ext     = '0;
        rem_ext     = '0;
        case (r_state)
            lnds_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    n_value = i_in.value;
                    n_lo    = '0;
                    if (i_in.start_req) begin
                        n_hi  = '0;
                        n_len = '0;
                        n_cnt = '0;
                        n_ovf = 1'b0;
                    end else begin
                        n_hi = r_len;
                    end
                    n_mid = n_hi >> 1;
                    rd_en = n_hi != '0;
                end
            end
            lnds_pkg::ST_SEARCH: begin
                if (tail_gt) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + LW'(1);
                end
                n_mid = n_lo + ((n_hi - n_lo) >> 1);
                rd_en = n_lo < n_hi;
            end
            lnds_pkg::ST_WRITE: begin
                if (slot_free) begin
                    if (r_lo < r_len) begin
                        wr_en   = 1'b1;
                        wr_addr = r_lo[AW-1:0];
                    end else if (r_len < LW'(MAX_LEN)) begin
                        wr_en   = 1'b1;
                        wr_addr = r_len[AW-1:0];
                        wb_len  = r_len + LW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_len = wb_len;
                    if (r_cnt != '1) begin
                        n_cnt = r_cnt + CW'(1);
                    end
                    run_ext     = {{RW{1'b0}}, wb_len};
                    rem_ext     = {{LW{1'b0}}, n_cnt} - {{CW{1'b0}}, wb_len};
                    n_out_valid = 1'b1;
                    n_out_run   = run_ext[RW-1:0];
                    n_out_rem   = rem_ext[CW-1:0];
                    n_out_ovf   = n_ovf;
                end
            end
            default: begin
            end
        endcase
        rd_addr = n_mid[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lnds_pkg::ST_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_value   <= n_value;
        r_out_run <= n_out_run;
        r_out_rem <= n_out_rem;
        r_out_ovf <= n_out_ovf;
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.run_length    = r_out_run;
    assign o_out.removed_count = r_out_rem;
    assign o_out.overflow      = r_out_ovf;

endmodule

@@ bench/lnds_checker.sv @@
// Checker that predicts the run length, removal count and overflow flag and compares each result.
module lnds_checker #(
    parameter int MAX_LEN = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lnds_in_if   i_req,
    lnds_out_if  i_res,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_MAX = (1 << lnds_pkg::COUNT_W) - 1;

    typedef struct packed {
        logic [lnds_pkg::RUN_W-1:0]   run_length;
        logic [lnds_pkg::COUNT_W-1:0] removed_count;
        logic                         overflow;
    } t_result;

    logic signed [lnds_pkg::VALUE_W-1:0] tails [MAX_LEN];
    int      tail_len;
    int      seen;
    bit      full_dropped;
    t_result awaited_results[$];
    int      fail_total;
    int      checked_total;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;

    function automatic t_result advance_run(input logic signed [lnds_pkg::VALUE_W-1:0] v,
                                            input logic clear);
        int      lo;
        int      hi;
        int      mid;
        t_result r;
        if (clear) begin
            tail_len     = 0;
            seen         = 0;
            full_dropped = 1'b0;
        end
        lo = 0;
        hi = tail_len;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tails[mid] > v) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        if (lo < tail_len) begin
            tails[lo] = v;
        end else if (tail_len < MAX_LEN) begin
            tails[tail_len] = v;
            tail_len++;
        end else begin
            full_dropped = 1'b1;
        end
        if (seen < COUNT_MAX) begin
            seen++;
        end
        r.run_length    = lnds_pkg::RUN_W'(tail_len);
        r.removed_count = lnds_pkg::COUNT_W'(seen - tail_len);
        r.overflow      = full_dropped;
        return r;
    endfunction

    task automatic note_mismatch(input string line);
        $display("[%0t] %s", $time, line);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            tail_len     = 0;
            seen         = 0;
            full_dropped = 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                awaited_results.push_back(advance_run(i_req.value, i_req.start_req));
            end
            if (i_res.valid && i_res.ready) begin
                if (awaited_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected result: run_length %0d removed %0d",
                                            i_res.run_length, i_res.removed_count));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_res.run_length !== want.run_length) begin
                        note_mismatch($sformatf("result %0d: run_length %0d, expected %0d",
                                                checked_total, i_res.run_length,
                                                want.run_length));
                    end
                    if (i_res.removed_count !== want.removed_count) begin
                        note_mismatch($sformatf("result %0d: removed_count %0d, expected %0d",
                                                checked_total, i_res.removed_count,
                                                want.removed_count));
                    end
                    if (i_res.overflow !== want.overflow) begin
                        note_mismatch($sformatf("result %0d: overflow %0b, expected %0b",
                                                checked_total, i_res.overflow, want.overflow));
                    end
                    checked_total++;
                end
            end
        end
        o_outstanding <= awaited_results.size();
    end

endmodule

@@ bench/tb_longest_nondecreasing_subsequence.sv @@
// Testbench top: clock, reset, request stimulus, result back-pressure and the final verdict.
module tb_longest_nondecreasing_subsequence;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN         = 1024;
    localparam int RANDOM_REQUESTS = 480;
    localparam int RUN_LIMIT       = 5_000_000;

    typedef enum int {
        SHAPE_WIDE,
        SHAPE_NARROW,
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_CORNER
    } t_shape;

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   stall_left;
    int   cycle_count;
    int   sent_total;
    int   random_sent;
    int   fail_count;
    int   outstanding;
    int   checked;

    lnds_in_if  in_if ();
    lnds_out_if out_if ();

    longest_nondecreasing_subsequence #(
        .MAX_LEN(MAX_LEN)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    lnds_checker #(
        .MAX_LEN(MAX_LEN)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (in_if),
        .i_res        (out_if),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        int pick;
        if (quiet) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 85) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            stall_left   <= draw_gap();
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic push_request(input logic signed [lnds_pkg::VALUE_W-1:0] v,
                                input logic clear);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.value     <= v;
        in_if.start_req <= clear;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_total++;
    endtask

    task automatic run_sequence(input int n, input t_shape shape);
        logic signed [lnds_pkg::VALUE_W-1:0] v;
        int                                  walk;
        walk = int'($urandom_range(0, 2000)) - 1000;
        for (int k = 0; k < n; k++) begin
            case (shape)
                SHAPE_WIDE: begin
                    v = $urandom;
                end
                SHAPE_NARROW: begin
                    v = int'($urandom_range(0, 16)) - 8;
                end
                SHAPE_RISING: begin
                    walk += int'($urandom_range(0, 3));
                    if ($urandom_range(0, 9) == 0) begin
                        walk -= int'($urandom_range(1, 40));
                    end
                    v = walk;
                end
                SHAPE_FALLING: begin
                    walk -= int'($urandom_range(0, 3));
                    if ($urandom_range(0, 9) == 0) begin
                        walk += int'($urandom_range(1, 40));
                    end
                    v = walk;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: v = 32'sh8000_0000;
                        1: v = 32'sh7fff_ffff;
                        2: v = 0;
                        3: v = -1;
                        4: v = 1;
                        default: v = $urandom;
                    endcase
                end
            endcase
            push_request(v, (k == 0) || ($urandom_range(0, 99) < 2));
        end
    endtask

    task automatic fill_table();
        int walk;
        walk = -int'($urandom_range(0, 100000));
        push_request(walk, 1'b1);
        for (int k = 1; k < MAX_LEN + 8; k++) begin
            walk += int'($urandom_range(0, 2));
            push_request(walk, 1'b0);
        end
        for (int k = 0; k < 12; k++) begin
            push_request(k[0] ? walk - int'($urandom_range(0, 500))
                              : walk + int'($urandom_range(0, 9)), 1'b0);
        end
    endtask

    initial begin
        int     n;
        t_shape shape;
        in_if.valid     = 1'b0;
        in_if.value     = '0;
        in_if.start_req = 1'b0;
        out_if.ready    = 1'b0;
        i_rst_n         = 1'b0;
        quiet           = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Negative appends on an empty table, the extremes and equal values.
        push_request(32'sh8000_0000, 1'b1);
        push_request(-7, 1'b0);
        push_request(-7, 1'b0);
        push_request(-3, 1'b0);
        push_request(32'sh7fff_ffff, 1'b0);
        push_request(32'sh7fff_ffff, 1'b0);
        push_request(32'sh8000_0000, 1'b0);
        push_request(0, 1'b0);
        push_request(-1, 1'b0);
        push_request(5, 1'b0);
        push_request(5, 1'b0);
        push_request(32'sh7fff_ffff, 1'b1);
        push_request(32'sh8000_0000, 1'b0);
        push_request(-1, 1'b1);
        push_request(-2, 1'b1);
        push_request(32'sh5555_5555, 1'b0);
        push_request(32'shAAAA_AAAA, 1'b0);
        push_request(1, 1'b0);
        push_request(0, 1'b0);
        push_request(32'sh7fff_fffe, 1'b0);
        push_request(32'sh7fff_ffff, 1'b0);

        fill_table();

        random_sent = 0;
        while (random_sent < RANDOM_REQUESTS) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(61, 300) : $urandom_range(1, 60);
            if (n > RANDOM_REQUESTS - random_sent) begin
                n = RANDOM_REQUESTS - random_sent;
            end
            shape = t_shape'($urandom_range(0, 4));
            quiet = ($urandom_range(0, 4) == 0);
            run_sequence(n, shape);
            random_sent += n;
        end
        quiet = 1'b0;

        run_sequence(10, SHAPE_WIDE);

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results, including a full tail table",
                 sent_total, checked);
        $display("with dropped appends, restarts mid-stream and values at both signed extremes.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/lnds_pkg.sv
hw/rtl/lnds_if.sv
hw/rtl/longest_nondecreasing_subsequence.sv
bench/lnds_checker.sv
bench/tb_longest_nondecreasing_subsequence.sv
